@@ hdl/ilvp_pkg.sv @@
// Shared constants, types and codes for the integer literal value parser.
package ilvp_pkg;

   // Width of the signed result word; the value itself keeps one bit less.
   localparam int VALUE_BITS = 64;
   localparam int ACC_BITS   = VALUE_BITS - 1;
   // Room for acc * 16 + 15 without loss.
   localparam int WIDE_BITS  = ACC_BITS + 5;
   // Result data padded to whole bytes.
   localparam int RSP_TDATA_BITS = ((ACC_BITS + 7) / 8) * 8;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
   localparam logic [7:0] CH_SEVEN   = 8'h37;  // '7'
   localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
   localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
   localparam logic [7:0] CH_UPPER_F = 8'h46;  // 'F'
   localparam logic [7:0] CH_UPPER_X = 8'h58;  // 'X'
   localparam logic [7:0] CH_UNDER   = 8'h5F;  // '_'
   localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
   localparam logic [7:0] CH_LOWER_B = 8'h62;  // 'b'
   localparam logic [7:0] CH_LOWER_F = 8'h66;  // 'f'
   localparam logic [7:0] CH_LOWER_X = 8'h78;  // 'x'

   localparam logic [3:0] DIGIT_TEN = 4'd10;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2,
      RADIX_OCT = 2'd3
   } radix_type;

   // Character classes of one input character.
   typedef struct packed {
      logic       is_nul;
      logic       is_under;
      logic       is_zero;
      logic       is_hex_prefix;  // 'x' or 'X'
      logic       is_bin_prefix;  // 'b'
      logic       is_octal;       // '0'..'7'
      logic       is_hex_digit;   // 0-9, a-f, A-F
      logic [3:0] digit;          // value when is_hex_digit
   } ilvp_class_type;

   typedef struct packed {
      logic                overflowed;
      logic [ACC_BITS-1:0] value;
   } ilvp_result_type;

endpackage

@@ hdl/integer_literal_value_parser.sv @@
// Top level of the integer literal value parser: input register, core, result register.
//
// Accepts one ASCII character per transfer on the req_ channel; the transfer
// with req_tlast high ends the literal and yields one rsp_ transfer carrying
// the value. Prefix 0x/0X selects hex, 0b binary, a leading 0 followed by
// 0-7 octal, anything else decimal. Underscores are skipped; scanning stops
// at the first character that is not a digit of the radix or at NUL, and
// later characters are ignored. A value above 2^63-1 reads as 0 with
// rsp_tuser set. Throughput is one character per clock: each character goes
// through one input register, combinational classify and multiply-add
// (radix multiply built from shifts and adds), and the state registers; the
// result register loads on the same edge as the state registers, so a final
// character passes the input register and then the result register before
// rsp_tvalid rises. Characters that do not end a literal keep flowing while a
// result waits; only a final character stalls behind an untaken result.
module integer_literal_value_parser (
   input  logic                                clock,
   input  logic                                reset,
   // input characters
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] ch
   input  logic                                req_tlast,   // last character
   // results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ilvp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,   // [62:0] value, [63] zero pad
   output logic                                rsp_tuser    // [0] overflowed
);
   import ilvp_pkg::*;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_ch_ff;
   logic                in_last_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ACC_BITS-1:0] rsp_value_ff;
   logic                rsp_ovf_ff;

   logic                advance;
   logic                req_xfer;
   ilvp_class_type      cls;
   ilvp_result_type     result;

   // A final character needs a free result slot; others never wait.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_comb begin
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_value_ff <= result.value;
         rsp_ovf_ff   <= result.overflowed;
      end
   end

   ilvp_decode u_decode (
      .ch  (in_ch_ff),
      .cls (cls)
   );

   ilvp_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .last   (in_last_ff),
      .cls    (cls),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'(rsp_value_ff);
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

@@ hdl/ilvp_decode.sv @@
// Character classifier: digit value and prefix/separator flags.
module ilvp_decode (
   input  logic [7:0]              ch,
   output ilvp_pkg::ilvp_class_type cls
);
   import ilvp_pkg::*;

   logic is_dec;
   logic is_low;
   logic is_up;

   assign is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_low = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_F);
   assign is_up  = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_F);

   always_comb begin
      cls               = '0;
      cls.is_nul        = (ch == CH_NUL);
      cls.is_under      = (ch == CH_UNDER);
      cls.is_zero       = (ch == CH_ZERO);
      cls.is_hex_prefix = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
      cls.is_bin_prefix = (ch == CH_LOWER_B);
      cls.is_octal      = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
      cls.is_hex_digit  = is_dec || is_low || is_up;
      if (is_dec) begin
         cls.digit = 4'(ch - CH_ZERO);
      end else if (is_low) begin
         cls.digit = 4'(ch - CH_LOWER_A) + DIGIT_TEN;
      end else if (is_up) begin
         cls.digit = 4'(ch - CH_UPPER_A) + DIGIT_TEN;
      end
   end

endmodule

@@ hdl/ilvp_accum.sv @@
// Literal state: prefix tracking, radix, accumulate with exact overflow check.
module ilvp_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      last,
   input  ilvp_pkg::ilvp_class_type  cls,
   output ilvp_pkg::ilvp_result_type result
);
   import ilvp_pkg::*;

   typedef enum logic [1:0] {
      POS_START     = 2'd0,
      POS_LEAD_ZERO = 2'd1,
      POS_BODY      = 2'd2
   } pos_type;

   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   radix_type            radix_ff, radix_in;
   pos_type              pos_ff, pos_in;
   logic                 halted_ff, halted_in;
   logic                 ovf_ff, ovf_in;

   radix_type            rad_eff;
   pos_type              pos_next;
   logic                 skip;
   logic                 digit_ok;
   logic [WIDE_BITS-1:0] acc_wide;
   logic [WIDE_BITS-1:0] prod;
   logic [WIDE_BITS-1:0] mac;
   logic                 overflow_hit;

   // prefix handling
   always_comb begin
      rad_eff  = radix_ff;
      pos_next = pos_ff;
      skip     = 1'b0;
      case (pos_ff)
         POS_LEAD_ZERO: begin
            pos_next = POS_BODY;
            if (cls.is_hex_prefix) begin
               rad_eff = RADIX_HEX;
               skip    = 1'b1;
            end else if (cls.is_bin_prefix) begin
               rad_eff = RADIX_BIN;
               skip    = 1'b1;
            end else if (cls.is_octal) begin
               rad_eff = RADIX_OCT;
            end
         end
         POS_START: begin
            pos_next = cls.is_zero ? POS_LEAD_ZERO : POS_BODY;
         end
         default: ;
      endcase
   end

   // digit legal in the current radix; multiply by radix as shifts and adds
   assign acc_wide = WIDE_BITS'(acc_ff);

   always_comb begin
      case (rad_eff)
         RADIX_HEX: begin
            digit_ok = cls.is_hex_digit;
            prod     = acc_wide << 4;
         end
         RADIX_BIN: begin
            digit_ok = cls.is_hex_digit && (cls.digit < 4'd2);
            prod     = acc_wide << 1;
         end
         RADIX_OCT: begin
            digit_ok = cls.is_hex_digit && (cls.digit < 4'd8);
            prod     = acc_wide << 3;
         end
         default: begin
            digit_ok = cls.is_hex_digit && (cls.digit < DIGIT_TEN);
            prod     = (acc_wide << 3) + (acc_wide << 1);
         end
      endcase
   end

   assign mac          = prod + WIDE_BITS'(cls.digit);
   assign overflow_hit = |mac[WIDE_BITS-1:ACC_BITS];

   always_comb begin
      acc_in    = acc_ff;
      radix_in  = radix_ff;
      pos_in    = pos_ff;
      halted_in = halted_ff;
      ovf_in    = ovf_ff;
      if (!halted_ff) begin
         if (cls.is_nul) begin
            halted_in = 1'b1;
         end else begin
            pos_in   = pos_next;
            radix_in = rad_eff;
            if (!skip && !cls.is_under) begin
               if (!digit_ok) begin
                  halted_in = 1'b1;
               end else if (overflow_hit) begin
                  ovf_in    = 1'b1;
                  halted_in = 1'b1;
                  acc_in    = '0;
               end else begin
                  acc_in = mac[ACC_BITS-1:0];
               end
            end
         end
      end
   end

   assign result.overflowed = ovf_in;
   assign result.value      = ovf_in ? '0 : acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         radix_ff  <= RADIX_DEC;
         pos_ff    <= POS_START;
         halted_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else if (step) begin
         if (last) begin
            acc_ff    <= '0;
            radix_ff  <= RADIX_DEC;
            pos_ff    <= POS_START;
            halted_ff <= 1'b0;
            ovf_ff    <= 1'b0;
         end else begin
            acc_ff    <= acc_in;
            radix_ff  <= radix_in;
            pos_ff    <= pos_in;
            halted_ff <= halted_in;
            ovf_ff    <= ovf_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last |=> acc_ff == '0 && pos_ff == POS_START && !halted_ff && !ovf_ff)
      else $error("state not cleared after final character");

   a_ovf_halts: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> halted_ff && acc_ff == '0)
      else $error("overflow without halt or with nonzero accumulator");

   a_halted_holds: assert property (@(posedge clock) disable iff (reset)
      halted_ff && step && !last |=> $stable(acc_ff) && $stable(radix_ff))
      else $error("accumulator moved while halted");

   a_radix_after_prefix: assert property (@(posedge clock) disable iff (reset)
      radix_ff != RADIX_DEC |-> pos_ff == POS_BODY)
      else $error("non-decimal radix before prefix decided");
`endif

endmodule

@@ test/tb_integer_literal_value_parser.sv @@
`timescale 1ns / 100ps
// Self-checking stream testbench for the integer literal value parser.
module tb_integer_literal_value_parser;
   import ilvp_pkg::*;

   // Largest value the result can carry: 2^63 - 1.
   localparam logic [63:0] VALUE_MAX     = (64'd1 << ACC_BITS) - 64'd1;
   localparam logic [4:0]  NOT_DIGIT     = 5'h1F;
   // Result path is two registers deep; a few spare cycles cover it.
   localparam int          SETTLE_CYCLES = 8;
   localparam int          DRAIN_LIMIT   = 5000;
   localparam int          HOLD_CYCLES   = 400;

   // Where the scan stands with respect to the radix prefix.
   typedef enum logic [1:0] {
      PFX_NONE,   // no character seen yet
      PFX_ZERO,   // first character was '0', prefix still open
      PFX_PAST    // prefix settled
   } prefix_state_type;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;   // [7:0] ch
   logic                      req_tlast  = 1'b0; // last character of the literal
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;         // [62:0] value, [63] zero pad
   logic                      rsp_tuser;         // [0] overflowed

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   integer_literal_value_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ---------------------------------------------------------------------
   // Value predictor: mirrors the parser's scan state, one character per
   // accepted transfer. A final character pushes one expected result.
   // ---------------------------------------------------------------------
   logic [ACC_BITS-1:0] lit_value;
   radix_type           lit_radix;
   prefix_state_type    lit_prefix;
   logic                lit_stopped;
   logic                lit_overflow;
   ilvp_result_type     expected_results[$];
   int                  mismatches = 0;

   function automatic logic [63:0] radix_base(radix_type r);
      case (r)
         RADIX_HEX: return 64'd16;
         RADIX_BIN: return 64'd2;
         RADIX_OCT: return 64'd8;
         default:   return 64'd10;
      endcase
   endfunction

   // Digit value of ch in radix r, NOT_DIGIT when it is no digit there.
   function automatic logic [4:0] digit_value(logic [7:0] ch, radix_type r);
      logic [4:0] d;
      d = NOT_DIGIT;
      if (ch >= CH_ZERO && ch <= CH_NINE) d = 5'(ch - CH_ZERO);
      else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) d = 5'(ch - CH_LOWER_A + DIGIT_TEN);
      else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) d = 5'(ch - CH_UPPER_A + DIGIT_TEN);
      if (64'(d) >= radix_base(r)) d = NOT_DIGIT;
      return d;
   endfunction

   function void clear_literal();
      lit_value    = '0;
      lit_radix    = RADIX_DEC;
      lit_prefix   = PFX_NONE;
      lit_stopped  = 1'b0;
      lit_overflow = 1'b0;
   endfunction

   function void scan_char(logic [7:0] ch);
      logic [4:0]  d;
      logic [63:0] base;
      if (lit_stopped) return;
      if (ch == CH_NUL) begin
         lit_stopped = 1'b1;
         return;
      end
      if (lit_prefix == PFX_ZERO) begin
         lit_prefix = PFX_PAST;
         // Prefix letters only choose the radix; they carry no digit.
         if (ch == CH_LOWER_X || ch == CH_UPPER_X) begin
            lit_radix = RADIX_HEX;
            return;
         end
         if (ch == CH_LOWER_B) begin
            lit_radix = RADIX_BIN;
            return;
         end
         // '0'..'7' after a leading zero is already the first octal digit.
         if (ch >= CH_ZERO && ch <= CH_SEVEN) lit_radix = RADIX_OCT;
      end else if (lit_prefix == PFX_NONE) begin
         lit_prefix = (ch == CH_ZERO) ? PFX_ZERO : PFX_PAST;
      end
      if (ch == CH_UNDER) return;
      d = digit_value(ch, lit_radix);
      if (d == NOT_DIGIT) begin
         lit_stopped = 1'b1;
         return;
      end
      base = radix_base(lit_radix);
      // Exact test: acc * base + d must stay within 2^63 - 1.
      if ({1'b0, lit_value} > (VALUE_MAX - 64'(d)) / base) begin
         lit_overflow = 1'b1;
         lit_stopped  = 1'b1;
         lit_value    = '0;
         return;
      end
      lit_value = ACC_BITS'(lit_value * base + 64'(d));
   endfunction

   function void accept_char(logic [7:0] ch, logic last);
      ilvp_result_type res;
      scan_char(ch);
      if (last) begin
         res.overflowed = lit_overflow;
         res.value      = lit_overflow ? '0 : lit_value;
         expected_results.push_back(res);
         clear_literal();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: every rsp transfer is matched to the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      ilvp_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer: value %0d overflowed %0b",
                   rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            exp_res = expected_results.pop_front();
            // Pad bit above the value must read zero as well.
            if (rsp_tdata !== RSP_TDATA_BITS'(exp_res.value)) begin
               $error("value mismatch: expected %0d, got %0d", exp_res.value, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser !== exp_res.overflowed) begin
               $error("overflowed mismatch: expected %0b, got %0b",
                      exp_res.overflowed, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls at stall_pct percent, plus a long hold-off
   // started by bumping hold_seq and counted down here.
   // ---------------------------------------------------------------------
   int stall_pct = 0;
   int hold_len  = 0;
   int hold_seq  = 0;
   int hold_seen = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen  <= hold_seq;
         hold_left  <= hold_len;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Sender: bursts of random length separated by random gaps. Valid stays
   // high across back-to-back transfers and drops only in a gap or a drain.
   // ---------------------------------------------------------------------
   int         gap_max    = 0;
   int         burst_max  = 1;
   int         burst_left = 0;
   int         chars_sent = 0;
   logic [7:0] lit_chars[$];

   task automatic send_char(logic [7:0] ch, logic last);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, gap_max);
         burst_left = $urandom_range(1, burst_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accept_char(ch, last);
      chars_sent++;
   endtask

   // Sends the buffered literal, tlast on its final character.
   task automatic send_literal();
      for (int i = 0; i < lit_chars.size(); i++)
         send_char(lit_chars[i], i == lit_chars.size() - 1);
      lit_chars.delete();
   endtask

   // Sender goes quiet until every expected result has come back.
   task automatic wait_drain();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      burst_left = 0;
      // At least one edge, so valid never drops and rises in one step.
      do begin
         @(posedge clock);
         n++;
      end while (expected_results.size() != 0 && n < DRAIN_LIMIT);
   endtask

   function void add_text(string s);
      for (int i = 0; i < s.len(); i++) lit_chars.push_back(s[i]);
   endfunction

   function automatic logic [7:0] digit_char(logic [63:0] v, logic upper);
      if (v < 64'd10) return CH_ZERO + v[7:0];
      return (upper ? CH_UPPER_A : CH_LOWER_A) + v[7:0] - 8'(DIGIT_TEN);
   endfunction

   function void add_prefix(radix_type r, logic upper);
      case (r)
         RADIX_HEX: begin
            lit_chars.push_back(CH_ZERO);
            lit_chars.push_back(upper ? CH_UPPER_X : CH_LOWER_X);
         end
         RADIX_BIN: begin
            lit_chars.push_back(CH_ZERO);
            lit_chars.push_back(CH_LOWER_B);
         end
         RADIX_OCT: lit_chars.push_back(CH_ZERO);
         default: ;
      endcase
   endfunction

   // Appends the digits of v in radix r, most significant first.
   function automatic void add_number(logic [63:0] v, radix_type r, logic upper);
      logic [7:0]  digs[$];
      logic [63:0] base;
      base = radix_base(r);
      do begin
         digs.push_front(digit_char(v % base, upper));
         v = v / base;
      end while (v != 0);
      foreach (digs[i]) lit_chars.push_back(digs[i]);
   endfunction

   // Mostly well-formed literals with random content; the rest is noise,
   // junk tails and prefixes that lead nowhere.
   function void build_random_literal();
      int          ndig;
      int          span;
      logic [63:0] base;
      logic [63:0] w;
      radix_type   r;
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 6)) lit_chars.push_back(8'($urandom_range(0, 255)));
         return;
      end
      r = radix_type'($urandom_range(0, 3));
      add_prefix(r, 1'($urandom_range(0, 1)));
      base = radix_base(r);
      if ($urandom_range(0, 99) < 10) begin
         // Long run of digits: lands on both sides of the overflow edge.
         w    = VALUE_MAX;
         span = 0;
         while (w != 0) begin
            w = w / base;
            span++;
         end
         ndig = $urandom_range(span - 1, span + 2);
      end else begin
         ndig = $urandom_range(0, 8);
      end
      for (int i = 0; i < ndig; i++) begin
         if ($urandom_range(0, 99) < 8) lit_chars.push_back(CH_UNDER);
         lit_chars.push_back(digit_char($urandom_range(0, 32'(base) - 1),
                                        1'($urandom_range(0, 1))));
      end
      if ($urandom_range(0, 99) < 20) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
               0: lit_chars.push_back(CH_NUL);
               1: add_text("B");
               2: lit_chars.push_back(8'($urandom_range(0, 255)));
               default: lit_chars.push_back(digit_char($urandom_range(0, 15), 1'b0));
            endcase
         end
      end
      if (lit_chars.size() == 0) lit_chars.push_back(8'($urandom_range(0, 255)));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Prefix forms, stop characters and the extremes of the character field.
   task automatic test_directed_literals();
      gap_max   = 2;
      burst_max = 4;
      stall_pct <= 30;
      add_text("0x1F"); send_literal();
      add_text("0X_a"); send_literal();   // upper prefix, underscore skipped
      add_text("0b");   send_literal();   // binary prefix, no digits
      add_text("0x");   send_literal();   // hex prefix, no digits
      add_text("017");  send_literal();   // octal
      add_text("08");   send_literal();   // leading zero then decimal digit
      add_text("0B1");  send_literal();   // capital B stops the scan
      add_text("1_2");  send_literal();
      add_text("0");    send_literal();   // single zero, prefix never decided
      add_text("5");                      // NUL ends the digits
      lit_chars.push_back(CH_NUL);
      add_text("7");
      send_literal();
      lit_chars.push_back(8'hFF);         // top character code, no digits
      send_literal();
      wait_drain();
   endtask

   // Largest value, one above it, one below it, and the largest with an
   // extra digit, in every radix.
   task automatic test_value_limits();
      radix_type r;
      gap_max   = 1;
      burst_max = 16;
      stall_pct <= 20;
      for (int k = 0; k < 4; k++) begin
         r = radix_type'(k);
         add_prefix(r, k[0]); add_number(VALUE_MAX, r, 1'b1);         send_literal();
         add_prefix(r, k[1]); add_number(VALUE_MAX + 64'd1, r, 1'b0); send_literal();
         add_prefix(r, 1'b0); add_number(VALUE_MAX - 64'd1, r, 1'b0); send_literal();
         add_prefix(r, 1'b1); add_number(VALUE_MAX, r, 1'b0);
         add_text("0");
         send_literal();
      end
      wait_drain();
   endtask

   // Receiver holds off while short literals keep coming: the result
   // register fills and the next final character stalls the input.
   task automatic test_backpressure();
      gap_max   = 0;
      burst_max = 1;
      stall_pct <= 0;
      hold_len  <= HOLD_CYCLES;
      hold_seq  <= hold_seq + 1;
      repeat (60) begin
         add_number($urandom_range(0, 999), RADIX_DEC, 1'b0);
         send_literal();
      end
      wait_drain();
   endtask

   task automatic test_random_traffic(int items, int gap_limit, int burst_limit, int stall);
      gap_max    = gap_limit;
      burst_max  = burst_limit;
      burst_left = 0;
      stall_pct <= stall;
      chars_sent = 0;
      while (chars_sent < items) begin
         build_random_literal();
         send_literal();
      end
   endtask

   initial begin
      clear_literal();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_literals();
      test_value_limits();
      test_backpressure();
      test_random_traffic(250, 0, 1, 0);     // full rate both sides
      test_random_traffic(350, 6, 8, 60);    // heavy idling
      wait_drain();
      test_random_traffic(350, 3, 20, 25);   // mixed
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
